// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the block's modules.
// Every check is clocked on clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication: cons must hold whenever ante holds.
`define CDO_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: cons must hold in the cycle after ante.
`define CDO_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/cdo_pkg.sv =====
// ----------------------------------------------------------------------------
// cdo_pkg
// Types, constants and calendar helpers for the date/time offset adder.
// ----------------------------------------------------------------------------
package cdo_pkg;

   localparam int SecPerMin     = 60;
   localparam int HourPerDay    = 24;
   localparam int MonthsPerYear = 12;
   localparam int YearDays      = 365;
   localparam int LongMonth     = 31;
   localparam int LeapFeb       = 29;
   localparam int LeapStep      = 4;
   localparam int LeapCentury   = 100;
   localparam int LeapQuad      = 400;

   // Widths of the internal arithmetic.
   localparam int DivW     = 17;            // widest sum fed to the divider
   localparam int RemW     = 6;             // remainder below 60
   localparam int QuotW    = 11;            // carries stay below 2048
   localparam int DaysW    = 17;            // whole days to walk
   localparam int YearW    = 12;
   localparam int LenW     = 9;             // 365 or 366

   // Reciprocals: n/60 = (n>>2)/15 and n/24 = (n>>3)/3, exact over 17-bit n.
   localparam int RcpW      = 16;
   localparam int Recip15   = 34953;        // ceil(2^19 / 15)
   localparam int Recip15Sh = 19;
   localparam int Recip3    = 21846;        // ceil(2^16 / 3)
   localparam int Recip3Sh  = 16;

   // Multiples of 25 that fit in the shifted year fields.
   localparam int Q25      = LeapCentury / LeapStep;
   localparam int Mult25Lo = (1 << (YearW - 2)) / Q25 + 1;
   localparam int Mult25Hi = (1 << (YearW - 4)) / Q25 + 1;

   localparam logic [4:0] MonthLen [0:12] = '{
      5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Division jobs, run in this order.
   typedef enum logic [2:0] {
      OP_SEC   = 3'd0,   // (s1 + s2) / 60
      OP_MIN   = 3'd1,   // (mi1 + mi2 + carry) / 60
      OP_HOUR  = 3'd2,   // (h1 + h2 + carry) % 24
      OP_DSEC  = 3'd3,   // s2 / 60
      OP_DMIN  = 3'd4,   // (mi2 + carry) / 60
      OP_DHOUR = 3'd5    // (h2 + carry) / 24
   } op_type;

   typedef struct packed {
      logic   load;
      logic   div_start;
      logic   div_store;
      op_type op;
      logic   walk_en;
      logic   out_load;
   } cdo_cmd_type;

   typedef struct packed {
      logic div_done;
      logic walk_more;
   } cdo_stat_type;

   // Gregorian leap test: y%400==0, or y%4==0 and y%100!=0.
   // y%100==0 is y%4==0 with (y>>2)%25==0; y%400==0 is y%16==0 with (y>>4)%25==0.
   function automatic logic is_leap(input logic [YearW-1:0] y);
      logic hit100;
      logic hit400;
      hit100 = 1'b0;
      hit400 = 1'b0;
      for (int k = 0; k < Mult25Lo; k++) begin
         if (y[YearW-1:2] == (YearW-2)'(k * Q25)) hit100 = 1'b1;
      end
      for (int k = 0; k < Mult25Hi; k++) begin
         if (y[YearW-1:4] == (YearW-4)'(k * Q25)) hit400 = 1'b1;
      end
      return (y[3:0] == 4'd0 && hit400) || (y[1:0] == 2'd0 && !hit100);
   endfunction

   // Month length; out-of-range months count as 31 days.
   function automatic logic [4:0] month_days(input logic [YearW-1:0] y,
                                             input logic [3:0] m);
      if (m == 4'd0 || m > 4'(MonthsPerYear)) return 5'(LongMonth);
      if (m == 4'd2 && is_leap(y)) return 5'(LeapFeb);
      return MonthLen[m];
   endfunction

endpackage

// ===== hdl/cdo_div.sv =====
// ----------------------------------------------------------------------------
// cdo_div
// Divider by 60 or 24 through reciprocal multiplication.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdo_div import cdo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            sel24,
   input  logic [DivW-1:0] numer,
   output logic            done,
   output logic [DivW-1:0] quot,
   output logic [RemW-1:0] rem
);

   localparam int DoneLag = 2;
   localparam int ProdW   = DivW - 2 + RcpW;

   logic             stage_ff;
   logic             done_ff;
   logic             sel24_ff;
   logic [DivW-1:0]  num_ff;
   logic [DivW-1:0]  quot_ff, quot_in;
   logic [ProdW-1:0] prod60, prod24;
   logic [DivW-1:0]  qd;

   // 60 = 4 * 15 and 24 = 8 * 3: drop the power of two, then multiply by
   // the reciprocal of the odd part.
   assign prod60  = ProdW'(num_ff[DivW-1:2]) * ProdW'(Recip15);
   assign prod24  = ProdW'(num_ff[DivW-1:3]) * ProdW'(Recip3);
   assign quot_in = sel24_ff ? DivW'(prod24 >> Recip3Sh) : DivW'(prod60 >> Recip15Sh);

   // q * 24 = q * 16 + q * 8, q * 60 = q * 64 - q * 4 (mod 2^17 is enough)
   assign qd      = sel24_ff ? (quot_ff << 4) + (quot_ff << 3)
                             : (quot_ff << 6) - (quot_ff << 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff   <= numer;
         sel24_ff <= sel24;
      end
      if (stage_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = RemW'(num_ff - qd);

   // A result shows up through the stage and done registers after its start.
   `CDO_ASSERT_IMP(a_div_lag, done_ff, $past(start, DoneLag), "divider done without start")

endmodule

// ===== hdl/cdo_dp.sv =====
// ----------------------------------------------------------------------------
// cdo_dp
// Datapath: request capture, carry divisions, calendar walk, result register.
// ----------------------------------------------------------------------------
module cdo_dp import cdo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cdo_cmd_type  cmd,
   output cdo_stat_type status,
   input  logic [11:0]  req_start_year,
   input  logic [3:0]   req_start_month,
   input  logic [4:0]   req_start_day,
   input  logic [4:0]   req_start_hour,
   input  logic [5:0]   req_start_minute,
   input  logic [5:0]   req_start_second,
   input  logic [15:0]  req_add_days,
   input  logic [15:0]  req_add_hours,
   input  logic [15:0]  req_add_minutes,
   input  logic [15:0]  req_add_seconds,
   output logic [11:0]  rsp_result_year,
   output logic [3:0]   rsp_result_month,
   output logic [4:0]   rsp_result_day,
   output logic [4:0]   rsp_result_hour,
   output logic [5:0]   rsp_result_minute,
   output logic [5:0]   rsp_result_second
);

   // captured request
   logic [4:0]  h1_ff;
   logic [5:0]  mi1_ff, s1_ff;
   logic [15:0] d2_ff, h2_ff, mi2_ff, s2_ff;

   // division results
   logic [QuotW-1:0] qs_ff, qm_ff, cq_ff;
   logic [5:0]       sec_ff, min_ff;
   logic [4:0]       hour_ff;

   // walk state
   logic [YearW-1:0] year_ff;
   logic [3:0]       month_ff;
   logic [4:0]       date_ff;
   logic [DaysW-1:0] days_ff;

   // result register
   logic [11:0] ry_ff;
   logic [3:0]  rmo_ff;
   logic [4:0]  rd_ff, rh_ff;
   logic [5:0]  rmi_ff, rs_ff;

   logic [DivW-1:0] numer, quot;
   logic [RemW-1:0] rem;
   logic            sel24, div_done, wrap;

   logic [4:0]       dim;
   logic [DaysW:0]   span;
   logic             more, feb_leap, year_ok;
   logic [YearW-1:0] y_next;
   logic [LenW-1:0]  year_len;
   logic [DaysW-1:0] days_step;

   cdo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .sel24 (sel24),
      .numer (numer),
      .done  (div_done),
      .quot  (quot),
      .rem   (rem)
   );

   assign sel24 = cmd.op == OP_HOUR || cmd.op == OP_DHOUR;

   always_comb begin
      case (cmd.op)
         OP_SEC:   numer = DivW'(s1_ff) + DivW'(s2_ff);
         OP_MIN:   numer = DivW'(mi1_ff) + DivW'(mi2_ff) + DivW'(qs_ff);
         OP_HOUR:  numer = DivW'(h1_ff) + DivW'(h2_ff) + DivW'(qm_ff);
         OP_DSEC:  numer = DivW'(s2_ff);
         OP_DMIN:  numer = DivW'(mi2_ff) + DivW'(cq_ff);
         OP_DHOUR: numer = DivW'(h2_ff) + DivW'(cq_ff);
         default:  numer = '0;
      endcase
   end

   // Time of day went backwards: one more whole day.
   assign wrap = {hour_ff, min_ff, sec_ff} < {h1_ff, mi1_ff, s1_ff};

   // Calendar walk step
   assign dim       = month_days(year_ff, month_ff);
   assign span      = {1'b0, days_ff} + (DaysW+1)'(date_ff);
   assign more      = span > (DaysW+1)'(dim);
   assign y_next    = year_ff + YearW'(1);
   assign feb_leap  = (month_ff <= 4'd2) ? is_leap(year_ff) : is_leap(y_next);
   assign year_len  = LenW'(YearDays) + LenW'(feb_leap);
   assign year_ok   = date_ff == 5'd1 && month_ff != 4'd0 &&
                      month_ff <= 4'(MonthsPerYear) && days_ff >= DaysW'(year_len);
   assign days_step = DaysW'(span - (DaysW+1)'(dim) - (DaysW+1)'(1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         h1_ff  <= req_start_hour;
         mi1_ff <= req_start_minute;
         s1_ff  <= req_start_second;
         d2_ff  <= req_add_days;
         h2_ff  <= req_add_hours;
         mi2_ff <= req_add_minutes;
         s2_ff  <= req_add_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.op)
            OP_SEC: begin
               qs_ff  <= quot[QuotW-1:0];
               sec_ff <= rem;
            end
            OP_MIN: begin
               qm_ff  <= quot[QuotW-1:0];
               min_ff <= rem;
            end
            OP_HOUR:  hour_ff <= rem[4:0];
            OP_DSEC:  cq_ff   <= quot[QuotW-1:0];
            OP_DMIN:  cq_ff   <= quot[QuotW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff  <= req_start_year;
         month_ff <= req_start_month;
         date_ff  <= req_start_day;
      end else if (cmd.div_store && cmd.op == OP_DHOUR) begin
         days_ff <= DaysW'(d2_ff) + quot + DaysW'(wrap);
      end else if (cmd.walk_en && more) begin
         if (year_ok) begin
            // whole year at once: twelve month steps from the first of a month
            year_ff <= y_next;
            days_ff <= days_ff - DaysW'(year_len);
         end else begin
            days_ff <= days_step;
            date_ff <= 5'd1;
            if (month_ff == 4'd0) begin
               month_ff <= 4'd1;
            end else if (month_ff < 4'(MonthsPerYear)) begin
               month_ff <= month_ff + 4'd1;
            end else begin
               month_ff <= 4'd1;
               year_ff  <= y_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ry_ff  <= year_ff;
         rmo_ff <= month_ff;
         rd_ff  <= date_ff + days_ff[4:0];   // walk leaves days within the month
         rh_ff  <= hour_ff;
         rmi_ff <= min_ff;
         rs_ff  <= sec_ff;
      end
   end

   assign status.div_done  = div_done;
   assign status.walk_more = more;

   assign rsp_result_year   = ry_ff;
   assign rsp_result_month  = rmo_ff;
   assign rsp_result_day    = rd_ff;
   assign rsp_result_hour   = rh_ff;
   assign rsp_result_minute = rmi_ff;
   assign rsp_result_second = rs_ff;

endmodule

// ===== hdl/cdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer: request intake, six divider jobs, calendar walk, result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdo_ctrl import cdo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  cdo_stat_type status,
   output cdo_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_WALK  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_store = 1'b0;
      cmd.op        = op_ff;
      cmd.walk_en   = 1'b0;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_SEC;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (op_ff == OP_DHOUR) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_ISSUE;
                  case (op_ff)
                     OP_SEC:  op_in = OP_MIN;
                     OP_MIN:  op_in = OP_HOUR;
                     OP_HOUR: op_in = OP_DSEC;
                     OP_DSEC: op_in = OP_DMIN;
                     default: op_in = OP_DHOUR;
                  endcase
               end
            end
         end
         ST_WALK: begin
            cmd.walk_en = 1'b1;
            if (!status.walk_more && out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CDO_ASSERT_IMP(a_done_in_wait, status.div_done, state_ff == ST_WAIT, "divider done outside wait")
   `CDO_ASSERT_NXT(a_walk_delivers, state_ff == ST_WALK && !status.walk_more && !rsp_valid_ff, rsp_valid_ff, "finished walk not delivered")

endmodule

// ===== hdl/calendar_datetime_offset_add.sv =====
// ----------------------------------------------------------------------------
// calendar_datetime_offset_add: Gregorian date/time plus day/hour/min/sec offsets
// The calendar walk takes N steps (one per whole year, one per single month,
// about 200 at most). One request at a time: the next one is taken only
// after the previous response is loaded. Sync reset.
// ----------------------------------------------------------------------------
//
// Flow of one request:
//   - capture the fields, then run six jobs through one shared divider
//     (by 60 or 24 through a reciprocal multiply, each job an issue state
//     then a wait for done): seconds carry, minutes carry, hour of day, and the
//     whole days hidden in the hour, minute and second offsets.
//   - add one day when the resulting time of day lies before the start.
//   - walk the day count forward: a whole year per cycle while sitting on
//     day 1 of a real month with at least a year's worth left, otherwise
//     one month per cycle. Leap years follow the Gregorian rule on the
//     12-bit year, which wraps past 4095.
//   - the result goes to an output register. If the previous response is
//     still waiting there, the finished walk simply holds.
// Odd inputs (month 0 or above 12, day past month end, day 0, oversized
// time fields) flow through the same arithmetic without special handling.
// Reset clears the sequencer and response valid; data registers are not reset.

module calendar_datetime_offset_add import cdo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_start_year,
   input  logic [3:0]  req_start_month,
   input  logic [4:0]  req_start_day,
   input  logic [4:0]  req_start_hour,
   input  logic [5:0]  req_start_minute,
   input  logic [5:0]  req_start_second,
   input  logic [15:0] req_add_days,
   input  logic [15:0] req_add_hours,
   input  logic [15:0] req_add_minutes,
   input  logic [15:0] req_add_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_result_year,
   output logic [3:0]  rsp_result_month,
   output logic [4:0]  rsp_result_day,
   output logic [4:0]  rsp_result_hour,
   output logic [5:0]  rsp_result_minute,
   output logic [5:0]  rsp_result_second
);

   cdo_cmd_type  cmd;
   cdo_stat_type status;

   // sequencer
   cdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, walk and response register
   cdo_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_start_year    (req_start_year),
      .req_start_month   (req_start_month),
      .req_start_day     (req_start_day),
      .req_start_hour    (req_start_hour),
      .req_start_minute  (req_start_minute),
      .req_start_second  (req_start_second),
      .req_add_days      (req_add_days),
      .req_add_hours     (req_add_hours),
      .req_add_minutes   (req_add_minutes),
      .req_add_seconds   (req_add_seconds),
      .rsp_result_year   (rsp_result_year),
      .rsp_result_month  (rsp_result_month),
      .rsp_result_day    (rsp_result_day),
      .rsp_result_hour   (rsp_result_hour),
      .rsp_result_minute (rsp_result_minute),
      .rsp_result_second (rsp_result_second)
   );

endmodule

// ===== tb/sv/datetime_offset_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_offset_checker
// Watches both channels of the date/time offset adder, predicts the result
// of every accepted request and compares each response field by field.
// ----------------------------------------------------------------------------

module datetime_offset_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [11:0] req_start_year,
   input  logic [3:0]  req_start_month,
   input  logic [4:0]  req_start_day,
   input  logic [4:0]  req_start_hour,
   input  logic [5:0]  req_start_minute,
   input  logic [5:0]  req_start_second,
   input  logic [15:0] req_add_days,
   input  logic [15:0] req_add_hours,
   input  logic [15:0] req_add_minutes,
   input  logic [15:0] req_add_seconds,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [11:0] rsp_result_year,
   input  logic [3:0]  rsp_result_month,
   input  logic [4:0]  rsp_result_day,
   input  logic [4:0]  rsp_result_hour,
   input  logic [5:0]  rsp_result_minute,
   input  logic [5:0]  rsp_result_second,
   output int          mismatch_count,
   output int          results_outstanding
);

   localparam int PrintCap = 30;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } datetime_type;

   datetime_type expected_datetimes[$];
   int           response_index;

   initial begin
      mismatch_count      = 0;
      results_outstanding = 0;
      response_index      = 0;
   end

   function automatic bit gregorian_leap(input logic [11:0] y);
      int yi;
      yi = y;
      return (yi % 400 == 0) || ((yi % 100 != 0) && (yi % 4 == 0));
   endfunction

   // Months outside 1..12 count as 31 days.
   function automatic int month_length(input logic [11:0] y, input logic [3:0] m);
      case (m)
         4'd2:                     return gregorian_leap(y) ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11:  return 30;
         default:                  return 31;
      endcase
   endfunction

   function automatic datetime_type predict_datetime_sum(
      input logic [11:0] y1, input logic [3:0] mo1, input logic [4:0] d1,
      input logic [4:0] h1, input logic [5:0] mi1, input logic [5:0] s1,
      input logic [15:0] d2, input logic [15:0] h2,
      input logic [15:0] mi2, input logic [15:0] s2);
      int unsigned  ssum, msum, hsum, sr, mr, hr;
      int unsigned  day_carry;
      int           days, date;
      logic [11:0]  yr;
      logic [3:0]   mon;
      datetime_type r;
      ssum = 32'(s1) + 32'(s2);
      msum = 32'(mi1) + 32'(mi2) + ssum / 60;
      hsum = 32'(h1) + 32'(h2) + msum / 60;
      sr   = ssum % 60;
      mr   = msum % 60;
      hr   = hsum % 24;
      // whole days hidden in the hour/minute/second offsets alone
      day_carry = (32'(h2) + (32'(mi2) + 32'(s2) / 60) / 60) / 24;
      days = int'(32'(d2) + day_carry);
      // time of day wrapped past midnight
      if (hr < h1 || (hr == h1 && mr < mi1) || (hr == h1 && mr == mi1 && sr < s1))
         days++;
      yr   = y1;
      mon  = mo1;
      date = d1;
      while (days > month_length(yr, mon) - date) begin
         days = days - (month_length(yr, mon) - date + 1);
         date = 1;
         if (mon == 4'd0) begin
            mon = 4'd1;
         end else if (mon < 4'd12) begin
            mon = mon + 4'd1;
         end else begin
            mon = 4'd1;
            yr  = yr + 12'd1;   // 12-bit wrap
         end
      end
      date     = date + days;
      r.year   = yr;
      r.month  = mon;
      r.day    = date[4:0];
      r.hour   = hr[4:0];
      r.minute = mr[5:0];
      r.second = sr[5:0];
      return r;
   endfunction

   task automatic report_failure(input string msg);
      if (mismatch_count < PrintCap)
         $display("%0t ns: response %0d: %s", $time, response_index, msg);
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin : monitor
      datetime_type want;
      if (!reset) begin
         // response side first: a request taken this edge cannot answer now
         if (rsp_valid && rsp_ready) begin
            if (expected_datetimes.size() == 0) begin
               report_failure("response with no request outstanding");
            end else begin
               want = expected_datetimes.pop_front();
               if (rsp_result_year !== want.year)
                  report_failure($sformatf("year got %0d want %0d",
                                           rsp_result_year, want.year));
               if (rsp_result_month !== want.month)
                  report_failure($sformatf("month got %0d want %0d",
                                           rsp_result_month, want.month));
               if (rsp_result_day !== want.day)
                  report_failure($sformatf("day got %0d want %0d",
                                           rsp_result_day, want.day));
               if (rsp_result_hour !== want.hour)
                  report_failure($sformatf("hour got %0d want %0d",
                                           rsp_result_hour, want.hour));
               if (rsp_result_minute !== want.minute)
                  report_failure($sformatf("minute got %0d want %0d",
                                           rsp_result_minute, want.minute));
               if (rsp_result_second !== want.second)
                  report_failure($sformatf("second got %0d want %0d",
                                           rsp_result_second, want.second));
            end
            response_index = response_index + 1;
         end
         if (req_valid && req_ready) begin
            expected_datetimes.push_back(predict_datetime_sum(
               req_start_year, req_start_month, req_start_day,
               req_start_hour, req_start_minute, req_start_second,
               req_add_days, req_add_hours, req_add_minutes, req_add_seconds));
         end
         results_outstanding <= expected_datetimes.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the date/time offset adder with directed and random requests under
// random backpressure; a separate checker predicts and compares responses.
// ----------------------------------------------------------------------------

module testbench;

   // Run shape.
   localparam int RandomRequests = 1930;
   localparam int DrainPauseAt   = 1000;   // sender waits for all responses here
   localparam int SteadyFirst    = 1200;   // sender never idles in this window
   localparam int SteadyLast     = 1400;
   localparam int IdlePercent    = 38;

   // Receiver timing, counted in cycles after reset.
   localparam int HoldStart  = 10000;      // long hold-off: block fills and stalls
   localparam int HoldLen    = 600;
   localparam int CalmStart  = 40000;      // receiver always ready in this window
   localparam int CalmEnd    = 55000;

   // Each request runs six divider jobs and a walk, so the tail and the watchdog
   // cover one full request plus the hold-off and random stalls several times.
   localparam int TailCycles     = 350;
   localparam int WatchdogLimit  = 4000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [11:0] req_start_year;
   logic [3:0]  req_start_month;
   logic [4:0]  req_start_day;
   logic [4:0]  req_start_hour;
   logic [5:0]  req_start_minute;
   logic [5:0]  req_start_second;
   logic [15:0] req_add_days;
   logic [15:0] req_add_hours;
   logic [15:0] req_add_minutes;
   logic [15:0] req_add_seconds;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_result_year;
   logic [3:0]  rsp_result_month;
   logic [4:0]  rsp_result_day;
   logic [4:0]  rsp_result_hour;
   logic [5:0]  rsp_result_minute;
   logic [5:0]  rsp_result_second;

   int mismatch_count;
   int results_outstanding;
   int stall_cycles;

   calendar_datetime_offset_add DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_year    (req_start_year),
      .req_start_month   (req_start_month),
      .req_start_day     (req_start_day),
      .req_start_hour    (req_start_hour),
      .req_start_minute  (req_start_minute),
      .req_start_second  (req_start_second),
      .req_add_days      (req_add_days),
      .req_add_hours     (req_add_hours),
      .req_add_minutes   (req_add_minutes),
      .req_add_seconds   (req_add_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_year   (rsp_result_year),
      .rsp_result_month  (rsp_result_month),
      .rsp_result_day    (rsp_result_day),
      .rsp_result_hour   (rsp_result_hour),
      .rsp_result_minute (rsp_result_minute),
      .rsp_result_second (rsp_result_second)
   );

   datetime_offset_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_year      (req_start_year),
      .req_start_month     (req_start_month),
      .req_start_day       (req_start_day),
      .req_start_hour      (req_start_hour),
      .req_start_minute    (req_start_minute),
      .req_start_second    (req_start_second),
      .req_add_days        (req_add_days),
      .req_add_hours       (req_add_hours),
      .req_add_minutes     (req_add_minutes),
      .req_add_seconds     (req_add_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_year     (rsp_result_year),
      .rsp_result_month    (rsp_result_month),
      .rsp_result_day      (rsp_result_day),
      .rsp_result_hour     (rsp_result_hour),
      .rsp_result_minute   (rsp_result_minute),
      .rsp_result_second   (rsp_result_second),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   // 12 ns clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request, optionally after a random idle gap, and return at the
   // edge where it is accepted. req_valid gets exactly one assignment per edge:
   // an idle gap lowers it and at least one edge passes before it rises again.
   task automatic send_request(input bit may_idle,
                               input logic [11:0] y, input logic [3:0] mo,
                               input logic [4:0] d, input logic [4:0] h,
                               input logic [5:0] mi, input logic [5:0] s,
                               input logic [15:0] ad, input logic [15:0] ah,
                               input logic [15:0] am, input logic [15:0] as);
      if (may_idle && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IdlePercent);
      end
      req_valid        <= 1'b1;
      req_start_year   <= y;
      req_start_month  <= mo;
      req_start_day    <= d;
      req_start_hour   <= h;
      req_start_minute <= mi;
      req_start_second <= s;
      req_add_days     <= ad;
      req_add_hours    <= ah;
      req_add_minutes  <= am;
      req_add_seconds  <= as;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering and wait for every outstanding response. The first edge
   // lets the checker count a request accepted on the current edge.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
   endtask

   // Random request: mostly well-formed timestamps with short offsets, some
   // odd fields (month 0 or 13..15, day 0, oversized time fields, years near
   // the 12-bit wrap) and a few offsets spanning the full 16 bits.
   task automatic send_random_request(input bit may_idle);
      logic [11:0] y;
      logic [3:0]  mo;
      logic [4:0]  d;
      logic [4:0]  h;
      logic [5:0]  mi;
      logic [5:0]  s;
      logic [15:0] ad, ah, am, as;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 70)      y = 12'($urandom_range(3800));
      else if (pick < 90) y = 12'($urandom_range(4095));
      else                y = 12'($urandom_range(4095, 4000));
      mo = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15));
      d  = ($urandom_range(99) < 85) ? 5'($urandom_range(28, 1)) : 5'($urandom_range(31));
      h  = ($urandom_range(99) < 90) ? 5'($urandom_range(23)) : 5'($urandom_range(31));
      mi = ($urandom_range(99) < 90) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
      s  = ($urandom_range(99) < 90) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
      // day offset sets the walk length: keep most short
      pick = $urandom_range(99);
      if (pick < 60)      ad = 16'($urandom_range(60));
      else if (pick < 85) ad = 16'($urandom_range(1000));
      else if (pick < 95) ad = 16'($urandom_range(65535));
      else                ad = 16'($urandom_range(65535, 60000));
      pick = $urandom_range(99);
      ah = (pick < 50) ? 16'($urandom_range(100)) :
           (pick < 80) ? 16'($urandom_range(5000)) : 16'($urandom_range(65535));
      pick = $urandom_range(99);
      am = (pick < 50) ? 16'($urandom_range(100)) :
           (pick < 80) ? 16'($urandom_range(5000)) : 16'($urandom_range(65535));
      pick = $urandom_range(99);
      as = (pick < 50) ? 16'($urandom_range(100)) :
           (pick < 80) ? 16'($urandom_range(5000)) : 16'($urandom_range(65535));
      send_request(may_idle, y, mo, d, h, mi, s, ad, ah, am, as);
   endtask

   // Receiver: random stalls, one long hold-off so the block backs up into
   // its request side, and one long stretch of constant readiness.
   initial begin : receiver
      int cycle_count;
      cycle_count = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cycle_count >= HoldStart && cycle_count < HoldStart + HoldLen)
            rsp_ready <= 1'b0;
         else if (cycle_count >= CalmStart && cycle_count < CalmEnd)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= IdlePercent);
         @(posedge clock);
         cycle_count++;
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("[calendar_datetime_offset_add] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      stall_cycles     <= 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      rsp_ready        <= 1'b0;
      req_start_year   <= '0;
      req_start_month  <= '0;
      req_start_day    <= '0;
      req_start_hour   <= '0;
      req_start_minute <= '0;
      req_start_second <= '0;
      req_add_days     <= '0;
      req_add_hours    <= '0;
      req_add_minutes  <= '0;
      req_add_seconds  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, leap rules, carries and the odd inputs.
      send_request(1, 12'd0,    4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'd0, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // February 28 plus one day: 400-year leap, century common, plain leap, common
      send_request(1, 12'd2000, 4'd2,  5'd28, 5'd12, 6'd0,  6'd0,  16'd1, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd1900, 4'd2,  5'd28, 5'd12, 6'd0,  6'd0,  16'd1, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2024, 4'd2,  5'd28, 5'd0,  6'd0,  6'd0,  16'd1, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2023, 4'd2,  5'd28, 5'd0,  6'd0,  6'd0,  16'd1, 16'd0, 16'd0, 16'd0);
      // one second ripples through minute, hour, day, month and year
      send_request(1, 12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 16'd0, 16'd0, 16'd0, 16'd1);
      // hour offset wraps past midnight
      send_request(1, 12'd2010, 4'd6,  5'd15, 5'd23, 6'd0,  6'd0,  16'd0, 16'd2, 16'd0, 16'd0);
      // month zero leaves to January of the same year, 13 to January next year
      send_request(1, 12'd2010, 4'd0,  5'd31, 5'd8,  6'd0,  6'd0,  16'd1, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2010, 4'd13, 5'd20, 5'd8,  6'd0,  6'd0,  16'd15, 16'd0, 16'd0, 16'd0);
      // day past month end spills even with nothing added
      send_request(1, 12'd2023, 4'd2,  5'd31, 5'd0,  6'd0,  6'd0,  16'd0, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2100, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  16'd0, 16'd0, 16'd0, 16'd0);
      // day zero: stays zero with nothing added, counts as the day before day 1
      send_request(1, 12'd2023, 4'd5,  5'd0,  5'd0,  6'd0,  6'd0,  16'd0, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2023, 4'd5,  5'd0,  5'd0,  6'd0,  6'd0,  16'd3, 16'd0, 16'd0, 16'd0);
      // oversized start time fields
      send_request(1, 12'd2023, 4'd5,  5'd10, 5'd31, 6'd63, 6'd63, 16'd0, 16'd0, 16'd0, 16'd0);
      // year counter wraps from 4095 to 0
      send_request(1, 12'd4095, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0,  16'd1, 16'd0, 16'd0, 16'd0);
      // offsets at full scale: seconds alone, hours and minutes together, days alone
      send_request(1, 12'd1234, 4'd7,  5'd4,  5'd5,  6'd6,  6'd7,  16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_request(1, 12'd1234, 4'd7,  5'd4,  5'd5,  6'd6,  6'd7,
                   16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_request(1, 12'd3800, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  16'hFFFF, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2400, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  16'd366, 16'd0, 16'd0, 16'd0);
      send_request(1, 12'd2047, 4'd14, 5'd30, 5'd22, 6'd58, 6'd58, 16'd2, 16'd1, 16'd1, 16'd1);
      wait_all_responses();

      for (int n = 0; n < RandomRequests; n++) begin
         if (n == DrainPauseAt) wait_all_responses();
         send_random_request(!(n >= SteadyFirst && n < SteadyLast));
      end

      // Drain, then give the block time to show any stray response.
      wait_all_responses();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0)
         $display("[calendar_datetime_offset_add] OK");
      else
         $display("[calendar_datetime_offset_add] ERROR");
      $finish;
   end

endmodule
